>>> hw/rtl/gbm_antithetic_path_step_macros.svh
// Assertion macros shared by the GBM path step RTL.
// Used by gbm_antithetic_path_step.sv; no other dependencies.
`ifndef GBM_ANTITHETIC_PATH_STEP_MACROS_SVH
`define GBM_ANTITHETIC_PATH_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gbm_pkg.sv
// Shared types, constants and tables for the GBM path step block.
// No dependencies; used by gbm_grow and gbm_antithetic_path_step.
package gbm_pkg;

   localparam int MAX_ASSETS_DEFAULT = 16;

   localparam logic [31:0] TIME_STEP_RESET = 32'd17043521;
   localparam logic [31:0] ROOT_STEP_RESET = 32'd270557600;

   localparam logic [47:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] LN2_Q24 = 24'd11629080;
   // floor(2^31 / ln2_q24), quotient estimate is low by at most one
   localparam logic [7:0] LN2_RECIP = 8'd184;
   localparam logic [7:0] K_BIAS = 8'd100;
   localparam logic signed [37:0] EXPO_HIGH = 38'sd558195840;   // 48 * ln2
   localparam logic signed [37:0] EXPO_LOW = -38'sd1162908000;  // -100 * ln2
   localparam logic signed [37:0] EXPO_BIAS = 38'sd1162908000;
   localparam logic [3:0] EXP_TERMS = 4'd12;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [31:0] DRIFT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] DRIFT_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      CSR_TIME_STEP  = 2'd0,
      CSR_ROOT_STEP  = 2'd1,
      CSR_ANTITHETIC = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      C_IDLE, C_SQUARE, C_DIFF, C_DT_HI, C_DT_LO, C_DRIFT, C_LOAD_WR,
      C_READ, C_FETCH, C_EXPO, C_MAIN, C_MAIN_WAIT, C_MIRROR, C_MIRROR_WAIT,
      C_WRITE, C_EMIT
   } ctl_state_type;

   typedef enum logic [3:0] {
      G_IDLE, G_QUOT, G_REM, G_CORR, G_TMUL, G_TDIV, G_TCHK, G_TADD,
      G_PHI, G_PLO, G_SUM, G_SHIFT, G_FIN
   } grow_state_type;

   typedef struct packed {
      logic              start;
      logic [47:0]       price;
      logic signed [37:0] expo;
   } grow_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [47:0] price;
   } grow_rsp_type;

   // floor(2^32 / n), n = 1 uses 2^32-1 (the correction step fixes it up)
   function automatic logic [31:0] term_recip(input logic [3:0] n);
      logic [31:0] r;
      unique case (n)
         4'd1:    r = 32'hFFFF_FFFF;
         4'd2:    r = 32'd2147483648;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'd1073741824;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'd536870912;
         4'd9:    r = 32'd477218588;
         4'd10:   r = 32'd429496729;
         4'd11:   r = 32'd390451572;
         4'd12:   r = 32'd357913941;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/gbm_ifs.sv
// Handshake channel interfaces for the GBM path step block.
// Request, result and register-write channels; no dependencies.
interface gbm_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         asset_index;
   logic               start_path;
   logic signed [15:0] normal_sample;
   logic signed [31:0] drift_rate;
   logic [30:0]        volatility;
   logic [47:0]        spot_price;

   modport source (output valid, op, asset_index, start_path, normal_sample, drift_rate,
                   volatility, spot_price, input ready);
   modport sink (input valid, op, asset_index, start_path, normal_sample, drift_rate,
                 volatility, spot_price, output ready);
endinterface

interface gbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  out_asset;
   logic [47:0] price_main;
   logic [47:0] price_mirror;

   modport source (output valid, out_asset, price_main, price_mirror, input ready);
   modport sink (input valid, out_asset, price_main, price_mirror, output ready);
endinterface

interface gbm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/gbm_antithetic_path_step.sv
// Geometric Brownian motion path step with antithetic pairing. A load item gives
// no result. The time of a step item is set by the 12-term exponential series in
// gbm_grow, which steps through TMUL, TDIV, TCHK and TADD for each term and runs
// once for the main path and once more for the mirror path in antithetic mode.
// One item is worked on at a time; a finished result waits in the output register
// while the next item is taken. Per-asset coefficients and prices live in two
// memories with registered reads, read at the start of a step; a load writes both,
// and a step writes the price memory back at its end.
`include "gbm_antithetic_path_step_macros.svh"

module gbm_antithetic_path_step #(
   parameter int MAX_ASSETS = gbm_pkg::MAX_ASSETS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   gbm_req_if.sink   req_if,
   gbm_rsp_if.source rsp_if,
   gbm_csr_if.sink   csr_if
);

   localparam int ADDR_W = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;

   gbm_pkg::ctl_state_type state_ff, state_in;

   logic [31:0] time_step_ff, root_step_ff;
   logic        anti_ff;

   logic [3:0]        asset_ff;
   logic              start_ff;
   logic [15:0]       z_ff;
   logic [31:0]       mu_ff;
   logic [30:0]       vol_ff;
   logic [47:0]       spot_ff;
   logic [ADDR_W-1:0] addr_ff;

   // coef: drift [111:80], scale [79:48], spot [47:0]; price: main [95:48], mirror [47:0]
   logic [111:0] coef_mem [MAX_ASSETS];
   logic [95:0]  price_mem [MAX_ASSETS];
   logic [111:0] coef_rd_ff;
   logic [95:0]  price_rd_ff;

   logic [69:0] prod_ff;
   logic [37:0] mag_ff;
   logic        neg_ff;
   logic [53:0] acc_ff;
   logic [31:0] drift_ff;
   logic [47:0] cur_main_ff, cur_mirror_ff;
   logic signed [37:0] x_main_ff, x_mirror_ff;
   logic [47:0] pm_ff, pr_ff;

   logic        rsp_valid_ff;
   logic [3:0]  out_asset_ff;
   logic [47:0] out_main_ff, out_mirror_ff;

   logic        req_accept, idx_ok, csr_write, emit_load;
   logic        grow_wait;
   logic [37:0] mul_a;
   logic [31:0] mul_b;
   logic        coef_we, price_we;
   logic [111:0] coef_wdata;
   logic [95:0]  price_wdata;
   logic [38:0] diff;
   logic [54:0] sum_dt;
   logic [38:0] mag2;
   logic [31:0] drift_in;
   logic [15:0] zmag;
   logic [37:0] base_x, dif_x;

   gbm_pkg::grow_req_type grow_req;
   gbm_pkg::grow_rsp_type grow_rsp;

   gbm_grow u_grow (
      .clock    (clock),
      .reset    (reset),
      .grow_req (grow_req),
      .grow_rsp (grow_rsp)
   );

   assign req_accept = req_if.valid && req_if.ready;
   assign idx_ok     = ({28'd0, req_if.asset_index} < 32'(MAX_ASSETS));
   assign csr_write  = csr_if.valid && csr_if.ready;
   assign csr_if.ready = 1'b1;
   assign emit_load  = (state_ff == gbm_pkg::C_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   assign grow_wait  = (state_ff == gbm_pkg::C_MAIN_WAIT) ||
                       (state_ff == gbm_pkg::C_MIRROR_WAIT);

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_asset    = out_asset_ff;
   assign rsp_if.price_main   = out_main_ff;
   assign rsp_if.price_mirror = out_mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbm_pkg::C_IDLE;
         time_step_ff <= gbm_pkg::TIME_STEP_RESET;
         root_step_ff <= gbm_pkg::ROOT_STEP_RESET;
         anti_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_if.index)
               gbm_pkg::CSR_TIME_STEP:  time_step_ff <= csr_if.data;
               gbm_pkg::CSR_ROOT_STEP:  root_step_ff <= csr_if.data;
               gbm_pkg::CSR_ANTITHETIC: anti_ff <= csr_if.data[0];
               default: ;
            endcase
         end
         if (emit_load) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbm_pkg::C_IDLE: begin
            if (req_accept && idx_ok) begin
               if (req_if.op == gbm_pkg::OP_LOAD) state_in = gbm_pkg::C_SQUARE;
               else state_in = gbm_pkg::C_READ;
            end
         end
         gbm_pkg::C_SQUARE:  state_in = gbm_pkg::C_DIFF;
         gbm_pkg::C_DIFF:    state_in = gbm_pkg::C_DT_HI;
         gbm_pkg::C_DT_HI:   state_in = gbm_pkg::C_DT_LO;
         gbm_pkg::C_DT_LO:   state_in = gbm_pkg::C_DRIFT;
         gbm_pkg::C_DRIFT:   state_in = gbm_pkg::C_LOAD_WR;
         gbm_pkg::C_LOAD_WR: state_in = gbm_pkg::C_IDLE;
         gbm_pkg::C_READ:    state_in = gbm_pkg::C_FETCH;
         gbm_pkg::C_FETCH:   state_in = gbm_pkg::C_EXPO;
         gbm_pkg::C_EXPO:    state_in = gbm_pkg::C_MAIN;
         gbm_pkg::C_MAIN:    state_in = gbm_pkg::C_MAIN_WAIT;
         gbm_pkg::C_MAIN_WAIT: begin
            if (grow_rsp.done) state_in = anti_ff ? gbm_pkg::C_MIRROR : gbm_pkg::C_WRITE;
         end
         gbm_pkg::C_MIRROR:  state_in = gbm_pkg::C_MIRROR_WAIT;
         gbm_pkg::C_MIRROR_WAIT: if (grow_rsp.done) state_in = gbm_pkg::C_WRITE;
         gbm_pkg::C_WRITE:   state_in = gbm_pkg::C_EMIT;
         gbm_pkg::C_EMIT:    if (emit_load) state_in = gbm_pkg::C_IDLE;
         default:            state_in = gbm_pkg::C_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_if.ready = (state_ff == gbm_pkg::C_IDLE);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         gbm_pkg::C_SQUARE: begin
            mul_a = 38'(vol_ff);
            mul_b = 32'(vol_ff);
         end
         gbm_pkg::C_DT_HI: begin
            mul_a = mag_ff;
            mul_b = 32'(time_step_ff[31:16]);
         end
         gbm_pkg::C_DT_LO: begin
            mul_a = mag_ff;
            mul_b = 32'(time_step_ff[15:0]);
         end
         gbm_pkg::C_DRIFT: begin
            mul_a = 38'(vol_ff);
            mul_b = root_step_ff;
         end
         gbm_pkg::C_FETCH: begin
            mul_a = 38'(coef_rd_ff[79:48]);
            mul_b = 32'(zmag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      coef_we    = (state_ff == gbm_pkg::C_LOAD_WR);
      price_we   = (state_ff == gbm_pkg::C_LOAD_WR) || (state_ff == gbm_pkg::C_WRITE);
      coef_wdata = {drift_ff, prod_ff[63:32], spot_ff};
      if (state_ff == gbm_pkg::C_LOAD_WR) price_wdata = {spot_ff, spot_ff};
      else price_wdata = {pm_ff, anti_ff ? pr_ff : cur_mirror_ff};
      grow_req.start = (state_ff == gbm_pkg::C_MAIN) || (state_ff == gbm_pkg::C_MIRROR);
      grow_req.price = (state_ff == gbm_pkg::C_MIRROR) ? cur_mirror_ff : cur_main_ff;
      grow_req.expo  = (state_ff == gbm_pkg::C_MIRROR) ? x_mirror_ff : x_main_ff;
   end

   // load arithmetic: (mu - sigma^2/2) * dt, magnitude truncated, then saturated; also the step exponent parts
   always_comb begin
      diff   = {{7{mu_ff[31]}}, mu_ff} - {2'b0, prod_ff[61:25]};
      sum_dt = {1'b0, acc_ff} + 55'(prod_ff[53:16]);
      mag2   = sum_dt[54:16];
      if (neg_ff) begin
         drift_in = (mag2 > 39'd2147483648) ? gbm_pkg::DRIFT_MIN : (32'd0 - mag2[31:0]);
      end else begin
         drift_in = (mag2 > 39'd2147483647) ? gbm_pkg::DRIFT_MAX : mag2[31:0];
      end
      zmag   = z_ff[15] ? (16'd0 - z_ff) : z_ff;
      base_x = {{6{coef_rd_ff[111]}}, coef_rd_ff[111:80]};
      dif_x  = {2'b0, prod_ff[47:12]};
   end

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[addr_ff] <= coef_wdata;
      if (price_we) price_mem[addr_ff] <= price_wdata;
      coef_rd_ff  <= coef_mem[addr_ff];
      price_rd_ff <= price_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      prod_ff <= 70'(mul_a) * 70'(mul_b);
      if (req_accept) begin
         asset_ff <= req_if.asset_index;
         start_ff <= req_if.start_path;
         z_ff     <= req_if.normal_sample;
         mu_ff    <= req_if.drift_rate;
         vol_ff   <= req_if.volatility;
         spot_ff  <= req_if.spot_price;
         addr_ff  <= ADDR_W'(req_if.asset_index);
      end
      unique case (state_ff)
         gbm_pkg::C_DIFF: begin
            neg_ff <= diff[38];
            mag_ff <= diff[38] ? 38'(39'd0 - diff) : diff[37:0];
         end
         gbm_pkg::C_DT_LO: acc_ff <= prod_ff[53:0];
         gbm_pkg::C_DRIFT: drift_ff <= drift_in;
         gbm_pkg::C_FETCH: begin
            cur_main_ff   <= start_ff ? coef_rd_ff[47:0] : price_rd_ff[95:48];
            cur_mirror_ff <= start_ff ? coef_rd_ff[47:0] : price_rd_ff[47:0];
            pr_ff         <= '0;
         end
         gbm_pkg::C_EXPO: begin
            // mirror gets the exact negation of the diffusion term
            if (z_ff[15]) begin
               x_main_ff   <= signed'(base_x - dif_x);
               x_mirror_ff <= signed'(base_x + dif_x);
            end else begin
               x_main_ff   <= signed'(base_x + dif_x);
               x_mirror_ff <= signed'(base_x - dif_x);
            end
         end
         gbm_pkg::C_MAIN_WAIT: if (grow_rsp.done) pm_ff <= grow_rsp.price;
         gbm_pkg::C_MIRROR_WAIT: if (grow_rsp.done) pr_ff <= grow_rsp.price;
         default: ;
      endcase
      if (emit_load) begin
         out_asset_ff  <= asset_ff;
         out_main_ff   <= pm_ff;
         out_mirror_ff <= pr_ff;
      end
   end

   `GBM_ASSERT_NOW(a_grow_start_idle, clock, reset, grow_req.start, !grow_rsp.busy, "grow busy")
   `GBM_ASSERT_NOW(a_grow_done_waited, clock, reset, grow_rsp.done, grow_wait, "stray done")
   `GBM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept && idx_ok, !req_if.ready, "busy")

endmodule

>>> hw/rtl/gbm_grow.sv
// Multi-cycle price growth unit: price * exp(x), Q24.24 price, Q.24 exponent.
// Depends on gbm_pkg; one shared 33x33 multiplier, 12-term series.
module gbm_grow (
   input  logic                  clock,
   input  logic                  reset,
   input  gbm_pkg::grow_req_type grow_req,
   output gbm_pkg::grow_rsp_type grow_rsp
);

   gbm_pkg::grow_state_type state_ff, state_in;

   logic [47:0]  price_ff;
   logic [30:0]  y_ff;
   logic         high_ff, low_ff;
   logic [7:0]   q_ff;
   logic signed [7:0] k_ff;
   logic [31:0]  r32_ff;
   logic [32:0]  term_ff;
   logic [32:0]  e_ff;
   logic [31:0]  t_ff;
   logic [31:0]  qd_ff;
   logic [3:0]   n_ff;
   logic [56:0]  acc_ff;
   logic [80:0]  p_ff;
   logic [65:0]  prod_ff;
   logic [47:0]  result_ff;

   logic [32:0]  mul_a, mul_b;
   logic [30:0]  y_in;
   logic [30:0]  rem;
   logic         rem_ge;
   logic [7:0]   q_in;
   logic [8:0]   k_full;
   logic [23:0]  r_in;
   logic [31:0]  rem_t;
   logic [31:0]  term_in;
   logic [6:0]   sh_amt;
   logic [128:0] wide;
   logic [128:0] shifted;
   logic [47:0]  result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbm_pkg::G_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbm_pkg::G_IDLE:  if (grow_req.start) state_in = gbm_pkg::G_QUOT;
         gbm_pkg::G_QUOT:  state_in = gbm_pkg::G_REM;
         gbm_pkg::G_REM:   state_in = gbm_pkg::G_CORR;
         gbm_pkg::G_CORR:  state_in = gbm_pkg::G_TMUL;
         gbm_pkg::G_TMUL:  state_in = gbm_pkg::G_TDIV;
         gbm_pkg::G_TDIV:  state_in = gbm_pkg::G_TCHK;
         gbm_pkg::G_TCHK:  state_in = gbm_pkg::G_TADD;
         gbm_pkg::G_TADD: begin
            if (n_ff == gbm_pkg::EXP_TERMS) state_in = gbm_pkg::G_PHI;
            else state_in = gbm_pkg::G_TMUL;
         end
         gbm_pkg::G_PHI:   state_in = gbm_pkg::G_PLO;
         gbm_pkg::G_PLO:   state_in = gbm_pkg::G_SUM;
         gbm_pkg::G_SUM:   state_in = gbm_pkg::G_SHIFT;
         gbm_pkg::G_SHIFT: state_in = gbm_pkg::G_FIN;
         gbm_pkg::G_FIN:   state_in = gbm_pkg::G_IDLE;
         default:          state_in = gbm_pkg::G_IDLE;
      endcase
   end

   // outputs: multiplier operands and status
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         gbm_pkg::G_QUOT: begin
            mul_a = 33'(y_ff);
            mul_b = 33'(gbm_pkg::LN2_RECIP);
         end
         gbm_pkg::G_REM: begin
            mul_a = 33'(prod_ff[38:31]);
            mul_b = 33'(gbm_pkg::LN2_Q24);
         end
         gbm_pkg::G_TMUL: begin
            mul_a = term_ff;
            mul_b = {1'b0, r32_ff};
         end
         gbm_pkg::G_TDIV: begin
            mul_a = {1'b0, prod_ff[63:32]};
            mul_b = {1'b0, gbm_pkg::term_recip(n_ff)};
         end
         gbm_pkg::G_TCHK: begin
            mul_a = {1'b0, prod_ff[63:32]};
            mul_b = 33'(n_ff);
         end
         gbm_pkg::G_PHI: begin
            mul_a = 33'(price_ff[47:24]);
            mul_b = e_ff;
         end
         gbm_pkg::G_PLO: begin
            mul_a = 33'(price_ff[23:0]);
            mul_b = e_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      grow_rsp.busy  = (state_ff != gbm_pkg::G_IDLE);
      grow_rsp.done  = (state_ff == gbm_pkg::G_FIN);
      grow_rsp.price = result_ff;
   end

   // range reduction: y = x + 100*ln2, k = floor(y / ln2) - 100
   always_comb begin
      y_in   = 31'(grow_req.expo + gbm_pkg::EXPO_BIAS);
      rem    = y_ff - prod_ff[30:0];
      rem_ge = (rem >= 31'(gbm_pkg::LN2_Q24));
      q_in   = q_ff + 8'(rem_ge);
      k_full = {1'b0, q_in} - {1'b0, gbm_pkg::K_BIAS};
      r_in   = rem_ge ? 24'(rem - 31'(gbm_pkg::LN2_Q24)) : rem[23:0];
      // series term divide: estimate from reciprocal, then fix up by one
      rem_t   = t_ff - prod_ff[31:0];
      term_in = qd_ff + 32'(rem_t >= 32'(n_ff));
   end

   // final scale by 2^k and drop the Q.32 fraction, saturating high and flushing low to zero
   always_comb begin
      sh_amt  = k_ff[7] ? 7'(-k_ff) : 7'(k_ff);
      wide    = {48'd0, p_ff};
      shifted = k_ff[7] ? (wide >> sh_amt) : (wide << sh_amt);
      priority if (price_ff == '0 || low_ff) begin
         result_in = '0;
      end else if (high_ff || (|shifted[128:80])) begin
         result_in = gbm_pkg::PRICE_MAX;
      end else begin
         result_in = shifted[79:32];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 66'(mul_a) * 66'(mul_b);
      unique case (state_ff)
         gbm_pkg::G_IDLE: begin
            if (grow_req.start) begin
               price_ff <= grow_req.price;
               y_ff     <= y_in;
               high_ff  <= (grow_req.expo >= gbm_pkg::EXPO_HIGH);
               low_ff   <= (grow_req.expo < gbm_pkg::EXPO_LOW);
            end
         end
         gbm_pkg::G_REM: q_ff <= prod_ff[38:31];
         gbm_pkg::G_CORR: begin
            k_ff    <= signed'(k_full[7:0]);
            r32_ff  <= {r_in, 8'd0};
            term_ff <= gbm_pkg::ONE_Q32;
            e_ff    <= gbm_pkg::ONE_Q32;
            n_ff    <= 4'd1;
         end
         gbm_pkg::G_TDIV: t_ff <= prod_ff[63:32];
         gbm_pkg::G_TCHK: qd_ff <= prod_ff[63:32];
         gbm_pkg::G_TADD: begin
            term_ff <= {1'b0, term_in};
            e_ff    <= e_ff + 33'(term_in);
            n_ff    <= n_ff + 4'd1;
         end
         gbm_pkg::G_PLO: acc_ff <= prod_ff[56:0];
         gbm_pkg::G_SUM: p_ff <= {acc_ff, 24'd0} + 81'(prod_ff[56:0]);
         gbm_pkg::G_SHIFT: result_ff <= result_in;
         default: ;
      endcase
   end

endmodule
